@@ hw/rtl/pd_pkg.sv @@
// Shared constants, types and state codes for the Paillier decryption core.
package pd_pkg;

  localparam int MODULUS_BITS  = 55;
  localparam int N2_W          = 2 * MODULUS_BITS;
  localparam int CIPHER_LOW_W  = 64;
  localparam int CIPHER_HIGH_W = 46;
  localparam int CIPHER_W      = CIPHER_LOW_W + CIPHER_HIGH_W;
  localparam int STEP_MAX      = (N2_W > CIPHER_W) ? N2_W : CIPHER_W;
  localparam int CNT_W         = $clog2(STEP_MAX);
  localparam int ECNT_W        = $clog2(MODULUS_BITS);
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 64;
  localparam int REG_IDX_W     = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODULUS = 2'd0,
    REG_LAMBDA  = 2'd1,
    REG_MU      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [MODULUS_BITS-1:0] modulus;
    logic [MODULUS_BITS-1:0] lambda;
    logic [MODULUS_BITS-1:0] mu;
  } pd_key_t;

  // Operands of the shared modular adder.
  typedef struct packed {
    logic [N2_W-1:0] a;
    logic [N2_W-1:0] b;
    logic            cin;
    logic [N2_W-1:0] modulus;
    logic            reduce;
  } pd_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR_N,
    ST_RED_C,
    ST_SQ_SETUP,
    ST_MUL,
    ST_DEC,
    ST_DIV,
    ST_LFIX,
    ST_DONE
  } pd_state_t;

  typedef enum logic [1:0] {
    MK_SQ,
    MK_CM,
    MK_FIN
  } pd_mul_kind_t;

endpackage

@@ hw/rtl/pd_if.sv @@
// Stream interfaces for ciphertext items in and plaintext items out.
interface pd_cipher_if import pd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CIPHER_LOW_W-1:0]  cipher_low;
  logic [CIPHER_HIGH_W-1:0] cipher_high;

  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface

interface pd_plain_if import pd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODULUS_BITS-1:0] plaintext;
  logic                    key_error;

  modport source (output valid, output plaintext, output key_error, input ready);
  modport sink (input valid, input plaintext, input key_error, output ready);
endinterface

@@ hw/rtl/pd_modadd.sv @@
// Shared modular adder: a + b + cin, with one conditional subtract of the modulus.
module pd_modadd import pd_pkg::*; (
  input  pd_op_t          op,
  output logic [N2_W-1:0] sum_out,
  output logic            sub_taken
);

  logic [N2_W:0]   s;
  logic [N2_W+1:0] d;

  always_comb begin
    s         = {1'b0, op.a} + {1'b0, op.b} + (N2_W+1)'(op.cin);
    d         = {1'b0, s} - {2'b00, op.modulus};
    sub_taken = op.reduce && !d[N2_W+1];
    sum_out   = sub_taken ? d[N2_W-1:0] : s[N2_W-1:0];
  end

endmodule

@@ hw/rtl/pd_regs.sv @@
// APB key register file: modulus, lambda and mu.
module pd_regs import pd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output pd_key_t            key
);

  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MODULUS: key.modulus <= pwdata[MODULUS_BITS-1:0];
        REG_LAMBDA:  key.lambda  <= pwdata[MODULUS_BITS-1:0];
        REG_MU:      key.mu      <= pwdata[MODULUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODULUS: prdata = PDATA_W'(key.modulus);
      REG_LAMBDA:  prdata = PDATA_W'(key.lambda);
      REG_MU:      prdata = PDATA_W'(key.mu);
      default:     prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/paillier_decrypt_core.sv @@
// Paillier decryption core: sequencer and registers around one shared modular adder.
// Nearly every cycle of the work is one adder pass; the work grows with each one bit of
// lambda, and is shorter when the power is zero.
// One item is in work at a time; a finished result waits in the output register while
// the next item is accepted, from the following cycle. A modulus below 2 goes straight to done with a key error.
// Synchronous active-high reset clears the sequencer, output valid and the keys.
module paillier_decrypt_core import pd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pd_cipher_if.sink          cipher,
  pd_plain_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  pd_key_t      key;
  pd_state_t    state, state_next;
  pd_mul_kind_t kind;
  pd_op_t       op;

  logic [N2_W-1:0]         acc, n2, c_red, x, mcand, mplier;
  logic [CIPHER_W-1:0]     csh;
  logic [MODULUS_BITS-1:0] q, res_pt;
  logic                    res_err;
  logic [CNT_W-1:0]        cnt;
  logic [ECNT_W-1:0]       ecnt;
  logic                    phase;
  logic [N2_W-1:0]         unit_res;
  logic                    unit_sub;
  logic [N2_W-1:0]         mul_acc;
  logic                    mul_end, lambda_bit, in_acc, out_load;
  logic [MODULUS_BITS:0]   lval;
  logic [N2_W-1:0]         nz;

  assign pready = 1'b1;
  assign nz     = {{MODULUS_BITS{1'b0}}, key.modulus};

  pd_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .key(key)
  );

  pd_modadd u_modadd (.op(op), .sum_out(unit_res), .sub_taken(unit_sub));

  assign in_acc     = cipher.valid && cipher.ready;
  assign out_load   = (state == ST_DONE) && (!result.valid || result.ready);
  assign mul_end    = (state == ST_MUL) && phase && (cnt == '0);
  assign lambda_bit = key.lambda[ecnt];
  // In the second half of a multiply step the addend is taken only on a one bit.
  assign mul_acc    = (phase && !mplier[N2_W-1]) ? acc : unit_res;
  assign lval       = {1'b0, q} + (MODULUS_BITS+1)'(acc != '0);

  // Operand selection for the shared unit and input handshake.
  always_comb begin
    op         = '0;
    op.modulus = n2;
    cipher.ready = (state == ST_IDLE);
    case (state)
      ST_SQR_N: begin
        op.a = {acc[N2_W-2:0], 1'b0};
        op.b = key.modulus[cnt[ECNT_W-1:0]] ? nz : '0;
      end
      ST_RED_C: begin
        op.a      = acc;
        op.b      = acc;
        op.cin    = csh[CIPHER_W-1];
        op.reduce = 1'b1;
      end
      ST_MUL: begin
        op.a       = acc;
        op.b       = phase ? mcand : acc;
        op.reduce  = 1'b1;
        op.modulus = (kind == MK_FIN) ? nz : n2;
      end
      ST_DIV: begin
        op.a       = acc;
        op.b       = acc;
        op.cin     = mplier[N2_W-1];
        op.reduce  = 1'b1;
        op.modulus = nz;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) state_next = (key.modulus < MODULUS_BITS'(2)) ? ST_DONE : ST_SQR_N;
      end
      ST_SQR_N:    if (cnt == '0) state_next = ST_RED_C;
      ST_RED_C:    if (cnt == '0) state_next = ST_SQ_SETUP;
      ST_SQ_SETUP: state_next = ST_MUL;
      ST_MUL: begin
        if (mul_end) begin
          case (kind)
            MK_SQ: begin
              if (!lambda_bit) state_next = (ecnt == '0) ? ST_DEC : ST_SQ_SETUP;
            end
            MK_CM:   state_next = (ecnt == '0) ? ST_DEC : ST_SQ_SETUP;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_DEC:  state_next = (x == '0) ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt == '0) state_next = ST_LFIX;
      ST_LFIX: state_next = ST_MUL;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.plaintext <= res_pt;
      result.key_error <= res_err;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        csh     <= {cipher.cipher_high, cipher.cipher_low};
        acc     <= '0;
        cnt     <= CNT_W'(MODULUS_BITS - 1);
        res_pt  <= '0;
        res_err <= (key.modulus < MODULUS_BITS'(2));
      end
      ST_SQR_N: begin
        if (cnt == '0) begin
          n2  <= unit_res;
          acc <= '0;
          cnt <= CNT_W'(CIPHER_W - 1);
        end else begin
          acc <= unit_res;
          cnt <= cnt - 1'b1;
        end
      end
      ST_RED_C: begin
        acc <= unit_res;
        csh <= {csh[CIPHER_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          c_red <= unit_res;
          x     <= N2_W'(1);
          ecnt  <= ECNT_W'(MODULUS_BITS - 1);
        end
      end
      ST_SQ_SETUP: begin
        acc    <= '0;
        mcand  <= x;
        mplier <= x;
        cnt    <= CNT_W'(N2_W - 1);
        phase  <= 1'b0;
        kind   <= MK_SQ;
      end
      ST_MUL: begin
        phase <= !phase;
        if (mul_end && (kind == MK_SQ) && lambda_bit) begin
          // A one bit of lambda follows the square with a multiply by c.
          x      <= mul_acc;
          acc    <= '0;
          mcand  <= c_red;
          mplier <= mul_acc;
          cnt    <= CNT_W'(N2_W - 1);
          kind   <= MK_CM;
        end else begin
          acc <= mul_acc;
          if (phase) begin
            mplier <= {mplier[N2_W-2:0], 1'b0};
            cnt    <= cnt - 1'b1;
          end
          if (mul_end) begin
            case (kind)
              MK_SQ, MK_CM: begin
                x    <= mul_acc;
                ecnt <= ecnt - 1'b1;
              end
              default: res_pt <= mul_acc[MODULUS_BITS-1:0];
            endcase
          end
        end
      end
      ST_DEC: begin
        mplier <= x - N2_W'(1);
        acc    <= '0;
        q      <= '0;
        cnt    <= CNT_W'(N2_W - 1);
      end
      ST_DIV: begin
        acc    <= unit_res;
        q      <= {q[MODULUS_BITS-2:0], unit_sub};
        mplier <= {mplier[N2_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
      end
      ST_LFIX: begin
        // The rounded-up quotient can equal n, which reduces to zero.
        mcand  <= (lval >= {1'b0, key.modulus}) ? '0 : N2_W'(lval);
        mplier <= {{MODULUS_BITS{1'b0}}, key.mu};
        acc    <= '0;
        cnt    <= CNT_W'(N2_W - 1);
        phase  <= 1'b0;
        kind   <= MK_FIN;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/pd_checker.sv @@
// Port-level checks for the Paillier decryption core, bound to the top level.
module pd_checker import pd_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [MODULUS_BITS-1:0] plaintext,
  input logic                    key_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(plaintext) && $stable(key_error))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_error |-> plaintext == '0)
    else $error("key error with nonzero plaintext");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

endmodule

bind paillier_decrypt_core pd_checker u_pd_checker (
  .clk(clk), .rst(rst),
  .in_valid(cipher.valid), .in_ready(cipher.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .plaintext(result.plaintext), .key_error(result.key_error)
);

@@ tb/sv/pd_decrypt_checker.sv @@
// Watches the ciphertext, plaintext and register ports, predicts each plaintext and compares.
`timescale 1ns / 1ps
module pd_decrypt_checker import pd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pd_cipher_if               cin,
  pd_plain_if                pout,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 pending,
  output int                 errors
);

  typedef struct packed {
    logic                    key_error;
    logic [MODULUS_BITS-1:0] plaintext;
  } plain_t;

  logic [MODULUS_BITS-1:0] key_n, key_lambda, key_mu;
  plain_t                  plain_q[$];

  // Paillier decryption with g = n+1, done with wide vectors instead of bit-serial steps.
  function automatic plain_t decrypt_plain(logic [CIPHER_LOW_W-1:0] lo,
                                           logic [CIPHER_HIGH_W-1:0] hi);
    logic [255:0] n, nsq, c, x, l, t;
    plain_t       r;
    n = 256'(key_n);
    r = '0;
    if (n < 2) begin
      r.key_error = 1'b1;
      return r;
    end
    nsq = n * n;
    c = 256'({hi, lo}) % nsq;
    x = 256'd1;
    for (int i = MODULUS_BITS - 1; i >= 0; i--) begin
      x = (x * x) % nsq;
      if (key_lambda[i]) x = (x * c) % nsq;
    end
    if (x == 0) begin
      l = '0;
    end else begin
      t = x - 1;
      l = t / n + ((t % n) != 0 ? 256'd1 : 256'd0);
    end
    r.plaintext = MODULUS_BITS'((l * (256'(key_mu) % n)) % n);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  assign pending = plain_q.size();

  always @(posedge clk) begin
    plain_t want;
    if (rst) begin
      key_n      <= '0;
      key_lambda <= '0;
      key_mu     <= '0;
      plain_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          PADDR_W'(8 * REG_MODULUS): key_n      <= pwdata[MODULUS_BITS-1:0];
          PADDR_W'(8 * REG_LAMBDA):  key_lambda <= pwdata[MODULUS_BITS-1:0];
          PADDR_W'(8 * REG_MU):      key_mu     <= pwdata[MODULUS_BITS-1:0];
          default: ;
        endcase
      end
      if (cin.valid && cin.ready) plain_q.push_back(decrypt_plain(cin.cipher_low, cin.cipher_high));
      if (pout.valid && pout.ready) begin
        if (plain_q.size() == 0) begin
          report_mismatch("unexpected item", 64'(pout.plaintext), '0);
        end else begin
          want = plain_q.pop_front();
          if (pout.plaintext !== want.plaintext)
            report_mismatch("plaintext", 64'(pout.plaintext), 64'(want.plaintext));
          if (pout.key_error !== want.key_error)
            report_mismatch("key_error", 64'(pout.key_error), 64'(want.key_error));
        end
      end
    end
  end

  initial errors = 0;

endmodule

@@ tb/sv/tb_paillier_decrypt_core.sv @@
// Top of the Paillier decryption testbench: clock, reset, key loading and ciphertext stimulus.
`timescale 1ns / 1ps
module tb_paillier_decrypt_core;
  import pd_pkg::*;

  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(24);
  localparam logic [63:0] PRIME_P = 64'd179426549;
  localparam logic [63:0] PRIME_Q = 64'd179426491;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               quiet = 1'b0;
  int                 pending, errors;

  pd_cipher_if cin();
  pd_plain_if  pout();

  paillier_decrypt_core u_top (
    .clk(clk), .rst(rst), .cipher(cin.sink), .result(pout.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pd_decrypt_checker u_checker (
    .clk(clk), .rst(rst), .cin(cin), .pout(pout), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .pending(pending), .errors(errors)
  );

  always #6 clk = ~clk;

  initial begin
    cin.valid       = 1'b0;
    cin.cipher_low  = '0;
    cin.cipher_high = '0;
    pout.ready      = 1'b0;
  end

  always @(negedge clk) pout.ready <= quiet || ($urandom_range(99) >= 20);

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [63:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic load_key(logic [63:0] n, logic [63:0] lambda, logic [63:0] mu);
    write_reg(PADDR_W'(8 * REG_MODULUS), n);
    write_reg(PADDR_W'(8 * REG_LAMBDA), lambda);
    write_reg(PADDR_W'(8 * REG_MU), mu);
  endtask

  // Holds valid until the block takes the item; leaves valid high for a following item.
  task automatic send_cipher(logic [CIPHER_LOW_W-1:0] lo, logic [CIPHER_HIGH_W-1:0] hi);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 20) begin
      cin.valid = 1'b0;
      @(negedge clk);
    end
    cin.valid = 1'b1;
    cin.cipher_low = lo;
    cin.cipher_high = hi;
    do @(posedge clk); while (!cin.ready);
  endtask

  task automatic drain;
    @(negedge clk);
    cin.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic [CIPHER_LOW_W-1:0]  lo;
    logic [CIPHER_HIGH_W-1:0] hi;
    for (int i = 0; i < count; i++) begin
      lo = {$urandom, $urandom};
      hi = CIPHER_HIGH_W'({$urandom, $urandom});
      case ($urandom_range(3))
        0: hi = '0;
        1: hi = hi >> $urandom_range(45);
        default: ;
      endcase
      send_cipher(lo, hi);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Modulus zero and one are key errors; bits above the key width must be dropped.
    write_reg(PADDR_W'(8 * REG_MODULUS), 64'hFF80_0000_0000_0000);
    send_cipher('1, '1);
    send_cipher('0, '0);
    drain();
    load_key(64'd1, 64'd5, 64'd3);
    send_cipher(64'd7, '0);
    drain();

    // Smallest valid modulus with zero lambda, then an unreduced mu.
    load_key(64'd2, 64'd0, 64'd5);
    send_cipher(64'd3, '0);
    drain();
    write_reg(PADDR_W'(8 * REG_LAMBDA), 64'd1);
    send_cipher(64'd3, '0);
    send_cipher(64'd4, '0);
    send_cipher('1, '1);
    drain();

    // Proper key and an unused address: zero ciphertext, one, a multiple of n, an unreduced value and a patterned one.
    load_key(PRIME_P * PRIME_Q, (PRIME_P - 1) * (PRIME_Q - 1), 64'h0012_3456_789A_BCDE);
    write_reg(UNUSED_ADDR, '1);
    send_cipher('0, '0);
    send_cipher(64'd1, '0);
    send_cipher(PRIME_P * PRIME_Q, '0);
    send_cipher('1, '1);
    send_cipher(64'h5555_5555_5555_5555, 46'h2AAA_AAAA_AAAA);
    drain();

    // All key bits set.
    load_key('1, '1, '1);
    send_cipher('1, '1);
    send_cipher(64'hAAAA_AAAA_AAAA_AAAA, 46'h1555_5555_5555);
    send_cipher(64'd2, '0);
    drain();

    // Random ciphertexts under random keys; one stretch without any stalls.
    for (int k = 0; k < 5; k++) begin
      load_key({$urandom, $urandom} >> $urandom_range(9), {$urandom, $urandom},
               {$urandom, $urandom});
      quiet = (k == 2);
      send_random(8);
      drain();
      send_random(8);
      drain();
    end
    quiet = 1'b0;
    load_key(PRIME_P * PRIME_Q, (PRIME_P - 1) * (PRIME_Q - 1), {$urandom, $urandom});
    send_random(6);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("tb_paillier_decrypt_core OK");
    end else begin
      $display("tb_paillier_decrypt_core NOT OK");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("tb_paillier_decrypt_core NOT OK");
    $finish;
  end

endmodule
